// ===== design/pwm_period_duty_solver_top_defines.svh =====
// assertion macros of the checker file
`ifndef PWM_PERIOD_DUTY_SOLVER_TOP_DEFINES_SVH
`define PWM_PERIOD_DUTY_SOLVER_TOP_DEFINES_SVH

// property checked out of reset
`define PDS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked in and out of reset
`define PDS_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/pds_pkg.sv =====
// types, constants and per-stage functions of the pwm period/duty solver
package pds_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_CLOCK_HZ    = 2'd0;
  localparam logic [1:0] CFG_SQ_MODE     = 2'd1;
  localparam logic [1:0] CFG_DUTY_PREC   = 2'd2;
  localparam logic [1:0] CFG_PERIOD_PREC = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_INV  = 2'd1;
  localparam logic [1:0] ST_PREC = 2'd2;

  localparam logic [29:0] CLOCK_HZ_RST = 30'd100000000;
  localparam logic [6:0]  PREC_RST     = 7'd100;
  localparam logic [30:0] TWO_E9       = 31'd2000000000;
  localparam logic [32:0] FOUR_E9      = 33'd4000000000;
  localparam logic [61:0] ONE_E9       = 62'd1000000000;
  localparam logic [15:0] MAX16        = 16'hFFFF;
  // floor(2^63 / 2e9), reciprocal for the ideal divider
  localparam logic [32:0] RECIP_2E9    = 33'd4611686018;

  // quotient bits of each divider
  localparam int QW_HC = 47;
  localparam int QW_FQ = 30;
  localparam int QW_RC = 30;
  localparam int QW_ER = 38;

  // stage map
  localparam int S_MUL      = 0;
  localparam int S_D1       = S_MUL + 1;
  localparam int S_D2       = S_D1 + 1;
  localparam int S_D3       = S_D2 + 1;
  localparam int S_EXP      = S_D3 + 1;
  localparam int S_MIN      = S_EXP + 1;
  localparam int S_HC       = S_MIN + 1;
  localparam int S_HFIX     = S_HC + QW_HC;
  localparam int S_FQ       = S_HFIX + 1;
  localparam int S_FSH      = S_FQ + QW_FQ;
  localparam int S_RC       = S_FSH + 1;
  localparam int S_DIFF     = S_RC + QW_RC;
  localparam int S_ER       = S_DIFF + 1;
  localparam int S_FIN      = S_ER + QW_ER;
  localparam int NUM_STAGES = S_FIN + 1;

  typedef struct packed {
    logic [29:0] clock_hz;
    logic        sq_mode;
    logic [6:0]  duty_prec;
    logic [6:0]  period_prec;
  } cfg_t;

  // context carried down the pipeline
  typedef struct packed {
    logic        inv;
    logic [30:0] per;
    logic [30:0] dty;
    logic [4:0]  expo;
    logic [15:0] spd;
    logic [15:0] hc;
    logic [15:0] err;
    logic [1:0]  sts;
    logic [61:0] num;
    logic [30:0] rem;
    logic [30:0] dvs;
    logic [30:0] quo;
    logic        ovf;
  } ctx_t;

  // smallest exponent for a duty accuracy
  function automatic logic [4:0] min_exp(input logic [6:0] prec);
    logic [4:0] e;
    if (prec < 7'd1)       e = 5'd16;
    else if (prec < 7'd2)  e = 5'd7;
    else if (prec < 7'd4)  e = 5'd6;
    else if (prec < 7'd7)  e = 5'd5;
    else if (prec < 7'd13) e = 5'd4;
    else if (prec < 7'd25) e = 5'd3;
    else if (prec < 7'd50) e = 5'd2;
    else                   e = 5'd1;
    return e;
  endfunction

  // bit length of a 15 bit value
  function automatic logic [4:0] bit_len(input logic [14:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 15; i++) begin
      if (v[i]) n = 5'(i + 1);
    end
    return n;
  endfunction

  // one restoring division step, quotient bit shifted in at the bottom
  function automatic ctx_t div_step(input ctx_t c, input logic [5:0] b);
    ctx_t r;
    logic [31:0] rs;
    r = c;
    rs = {c.rem, c.num[b]};
    r.ovf = c.ovf | c.quo[30];
    if (rs >= {1'b0, c.dvs}) begin
      r.rem = 31'(rs - {1'b0, c.dvs});
      r.quo = {c.quo[29:0], 1'b1};
    end else begin
      r.rem = rs[30:0];
      r.quo = {c.quo[29:0], 1'b0};
    end
    return r;
  endfunction

  // work of stage k
  function automatic ctx_t stage_fn(input ctx_t c, input int k, input cfg_t cfg);
    ctx_t r;
    logic normal;
    logic [62:0] pm;
    logic [30:0] dv;
    logic [4:0] me;
    logic [4:0] k2;
    logic [31:0] q;
    logic [30:0] sp;
    logic [16:0] one;
    logic [15:0] h;
    logic [29:0] fq;
    logic [30:0] rc;
    logic [30:0] df;
    logic [15:0] e;
    r = c;
    normal = !cfg.sq_mode;
    if (k == S_MUL) begin
      // ideal divider numerator: period * clock + 1e9
      r.num = {31'd0, c.per} * {32'd0, cfg.clock_hz} + ONE_E9;
      r.quo = '0;
      r.ovf = 1'b0;
    end else if (k == S_D1) begin
      // quotient estimate from the upper numerator bits
      pm = 63'(c.num[60:31]) * 63'(RECIP_2E9);
      r.quo = 31'(pm >> 32);
    end else if (k == S_D2) begin
      // remainder of the estimate, below three divisors
      r.num = c.num - 62'(c.quo) * 62'(TWO_E9);
    end else if (k == S_D3) begin
      // estimate is short by at most two
      if (c.num >= 62'(FOUR_E9)) r.quo = c.quo + 31'd2;
      else if (c.num >= 62'(TWO_E9)) r.quo = c.quo + 31'd1;
    end else if (k == S_EXP) begin
      // exponent from the upper divider bits
      dv = (c.quo == '0) ? 31'd1 : c.quo;
      r.expo = normal ? bit_len(dv[30:16]) : 5'd0;
      r.quo = dv >> r.expo;
    end else if (k == S_MIN) begin
      // raise exponent to duty minimum, saturate speed
      me = min_exp(cfg.duty_prec);
      sp = c.quo - 31'd1;
      if (normal && c.expo < me) begin
        k2 = me - c.expo;
        q = ({1'b0, c.quo} + (32'd1 << (k2 - 5'd1))) >> k2;
        sp = (q == '0) ? 31'd0 : 31'(q - 32'd1);
        r.expo = me;
      end
      r.spd = (sp > 31'(MAX16)) ? MAX16 : sp[15:0];
      r.num = ({31'd0, c.dty} << r.expo) + 62'(c.per >> 1);
      r.dvs = c.per;
      r.rem = '0;
      r.quo = '0;
      r.ovf = 1'b0;
    end else if (k >= S_HC && k < S_HFIX) begin
      r = div_step(c, 6'(S_HFIX - 1 - k));
    end else if (k == S_HFIX) begin
      // high count pulled off the extremes
      h = c.quo[15:0];
      one = 17'd1 << c.expo;
      if (h == 16'd0 && c.dty != '0) h = 16'd1;
      else if (one <= {1'b0, h} && c.dty < c.per) h = h - 16'd1;
      r.hc = normal ? h : 16'd0;
      r.num = 62'(cfg.clock_hz) + 62'(c.spd) + 62'd1;
      r.dvs = 31'({c.spd, 1'b0}) + 31'd2;
      r.rem = 31'(r.num >> 30);
      r.quo = '0;
      r.ovf = 1'b0;
    end else if (k >= S_FQ && k < S_FSH) begin
      r = div_step(c, 6'(S_FSH - 1 - k));
    end else if (k == S_FSH) begin
      // reached frequency, never zero
      fq = c.quo[29:0];
      if (normal) fq = fq >> c.expo;
      if (fq == '0) fq = 30'd1;
      r.dvs = {1'b0, fq};
      r.num = ONE_E9 + 62'(fq >> 1);
      r.rem = 31'(r.num >> 30);
      r.quo = '0;
      r.ovf = 1'b0;
    end else if (k >= S_RC && k < S_DIFF) begin
      r = div_step(c, 6'(S_DIFF - 1 - k));
    end else if (k == S_DIFF) begin
      // absolute period difference scaled to percent
      rc = {1'b0, c.quo[29:0]};
      df = (rc > c.per) ? rc - c.per : c.per - rc;
      r.num = {31'd0, df} * 62'd100 + 62'(c.per >> 1);
      r.dvs = c.per;
      r.rem = 31'(r.num >> 38);
      r.quo = '0;
      r.ovf = 1'b0;
    end else if (k >= S_ER && k < S_FIN) begin
      r = div_step(c, 6'(S_FIN - 1 - k));
    end else if (k == S_FIN) begin
      // saturate error, decide status
      e = (c.ovf || c.quo[30:16] != '0) ? MAX16 : c.quo[15:0];
      if (c.inv) begin
        r.sts  = ST_INV;
        r.spd  = '0;
        r.expo = '0;
        r.hc   = '0;
        r.err  = '0;
      end else begin
        r.sts = (e > 16'(cfg.period_prec)) ? ST_PREC : ST_OK;
        r.err = e;
      end
    end
    return r;
  endfunction

endpackage

// ===== design/pds_pipe.sv =====
// register pipeline of the solver, one stage function per register stage
module pds_pipe (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           ce,
  input  logic           in_vld,
  input  pds_pkg::ctx_t  in_ctx,
  input  pds_pkg::cfg_t  cfg,
  output logic           out_vld,
  output pds_pkg::ctx_t  out_ctx
);

  pds_pkg::ctx_t st_r   [0:pds_pkg::NUM_STAGES];
  pds_pkg::ctx_t st_nxt [0:pds_pkg::NUM_STAGES-1];
  logic [pds_pkg::NUM_STAGES:0] vld_r;

  // stage logic
  for (genvar k = 0; k < pds_pkg::NUM_STAGES; k++) begin : g_stage
    always_comb begin
      st_nxt[k] = pds_pkg::stage_fn(st_r[k], k, cfg);
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        st_r[k+1] <= st_nxt[k];
      end
    end
  end

  // entry register
  always_ff @(posedge clk) begin
    if (ce) begin
      st_r[0] <= in_ctx;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[pds_pkg::NUM_STAGES-1:0], in_vld};
    end
  end

  assign out_vld = vld_r[pds_pkg::NUM_STAGES];
  assign out_ctx = st_r[pds_pkg::NUM_STAGES];

endmodule

// ===== design/pwm_period_duty_solver_top.sv =====
// top level of the pwm period/duty solver
// Converts a period and a high time in nanoseconds into prescaler speed,
// ratio exponent and high count, and checks the reached period error.
// Input channel in_*: one request per handshake, period and high time.
// Output channel out_*: one result per request, in request order.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr
// (0 clock frequency, 1 square output mode, 2 duty accuracy, 3 period tolerance);
// write only while no request is in flight.
// Pipeline: a three-stage reciprocal divide by 2e9 and four bit-per-stage
// restoring dividers in a row (47 + 30 + 30 + 38 steps) plus multiply and
// fix-up stages.
// Throughput: one request per cycle while the skid register is free.
// Reset: synchronous on rst_n low; clears all valid bits and loads the
// register defaults (100 MHz clock, normal mode, precisions 100).
// Stall: while out_tready is low the output register holds its result; one
// more result is caught in a skid register, after which in_tready drops
// and the whole pipeline freezes until the receiver takes data again.
module pwm_period_duty_solver_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // req_period[31:0], duty_ns[63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // status[1:0], speed_value[17:2],
                                  // ratio_exponent[22:18], high_count[38:23],
                                  // period_error_pct[54:39], zero[55]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [29:0] cfg_wdata
);

  logic [29:0]   clock_hz_r;
  logic          sq_mode_r;
  logic [6:0]    duty_prec_r;
  logic [6:0]    period_prec_r;
  pds_pkg::cfg_t cfg;
  pds_pkg::ctx_t in_ctx;
  pds_pkg::ctx_t pipe_ctx;
  logic          pipe_vld;
  logic          ce;
  logic          take;
  logic [55:0]   res;
  logic          out_vld_r;
  logic [55:0]   out_data_r;
  logic          skid_vld_r;
  logic [55:0]   skid_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r    <= pds_pkg::CLOCK_HZ_RST;
      sq_mode_r     <= 1'b0;
      duty_prec_r   <= pds_pkg::PREC_RST;
      period_prec_r <= pds_pkg::PREC_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pds_pkg::CFG_CLOCK_HZ:    clock_hz_r    <= cfg_wdata;
        pds_pkg::CFG_SQ_MODE:     sq_mode_r     <= cfg_wdata[0];
        pds_pkg::CFG_DUTY_PREC:   duty_prec_r   <= cfg_wdata[6:0];
        pds_pkg::CFG_PERIOD_PREC: period_prec_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  assign cfg.clock_hz    = clock_hz_r;
  assign cfg.sq_mode     = sq_mode_r;
  assign cfg.duty_prec   = duty_prec_r;
  assign cfg.period_prec = period_prec_r;

  // request decode: argument check and clamped duty
  always_comb begin
    in_ctx     = '0;
    in_ctx.per = in_tdata[30:0];
    in_ctx.dty = in_tdata[63] ? 31'd0 : in_tdata[62:32];
    in_ctx.inv = in_tdata[31] || (in_tdata[31:0] == 32'd0) ||
                 (!sq_mode_r && in_tdata[63]);
  end

  // pipeline advances while the skid register is free
  assign ce        = !skid_vld_r;
  assign in_tready = ce;

  pds_pipe u_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .in_vld  (in_tvalid),
    .in_ctx  (in_ctx),
    .cfg     (cfg),
    .out_vld (pipe_vld),
    .out_ctx (pipe_ctx)
  );

  assign take = ce && pipe_vld;
  assign res  = {1'b0, pipe_ctx.err, pipe_ctx.hc, pipe_ctx.expo,
                 pipe_ctx.spd, pipe_ctx.sts};

  // output register and skid control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= take;
      end
    end else if (take) begin
      skid_vld_r <= 1'b1;
    end
  end

  // output and skid data
  always_ff @(posedge clk) begin
    if (!out_vld_r || out_tready) begin
      out_data_r <= skid_vld_r ? skid_data_r : res;
    end else if (take) begin
      skid_data_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/pds_chk.sv =====
// port checker of the solver top level, with its bind
`include "pwm_period_duty_solver_top_defines.svh"

module pds_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  // stalled result holds
  `PDS_CHECK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // status code 3 is never produced
  `PDS_CHECK(a_sts_code, out_tvalid |-> out_tdata[1:0] != 2'd3, "bad status code")

  // an invalid request carries zero fields
  `PDS_CHECK(a_inv_zero, out_tvalid && out_tdata[1:0] == 2'd1 |-> out_tdata[55:2] == 54'd0, "invalid result not cleared")

  // exponent stays within the duty range
  `PDS_CHECK(a_exp_range, out_tvalid |-> out_tdata[22:18] <= 5'd16, "exponent out of range")

  // reset empties the output side
  `PDS_CHECK_RST(a_rst_empty, !rst_n |=> !out_tvalid && in_tready, "not empty after reset")

endmodule

bind pwm_period_duty_solver_top pds_chk u_pds_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/tb_pwm_period_duty_solver_top.sv =====
// testbench for the pwm period/duty solver: directed table, random requests, self-checking
`timescale 1ns / 1ps

module tb_pwm_period_duty_solver_top;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] speed;
    logic [4:0]  expo;
    logic [15:0] high_cnt;
    logic [15:0] err_pct;
  } solve_t;

  typedef struct {
    logic [31:0] period;
    logic [31:0] duty;
    bit          typed;
    solve_t      want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // req_period[31:0], duty_ns[63:32]
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // status[1:0], speed_value[17:2], ratio_exponent[22:18],
                           // high_count[38:23], period_error_pct[54:39], zero[55]
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [29:0] cfg_wdata;

  // register copies for the predictor
  logic [29:0] clk_hz_q;
  logic        clk_mode_q;
  logic [6:0]  duty_prec_q;
  logic [6:0]  per_prec_q;

  solve_t solutions_due[$];
  int     fail_cnt;
  int     req_cnt;
  int     res_cnt;
  int     idle_cycles;
  int     stall_left;
  bit     no_idle;

  localparam solve_t INVALID = '{status: pds_pkg::ST_INV, default: '0};

  pwm_period_duty_solver_top i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
    return (d == 0) ? 0 : (n + d / 2) / d;
  endfunction

  function automatic int unsigned min_exponent(logic [6:0] p);
    if (p < 1) return 16;
    if (p < 2) return 7;
    if (p < 4) return 6;
    if (p < 7) return 5;
    if (p < 13) return 4;
    if (p < 25) return 3;
    if (p < 50) return 2;
    return 1;
  endfunction

  // expected solution for one request under the current registers
  function automatic solve_t solve_pwm(logic [31:0] per_raw, logic [31:0] dty_raw);
    solve_t s;
    longint unsigned per, dty, dv, spd, hc, fq, rch, df, er, q, top;
    int unsigned ex, me;
    s = '0;
    if (per_raw[31] || per_raw == 0 || (!clk_mode_q && dty_raw[31])) return INVALID;
    per = per_raw;
    dty = dty_raw[31] ? 0 : dty_raw;
    hc = 0;
    ex = 0;
    dv = rdiv(per * clk_hz_q, 64'd2000000000);
    if (dv == 0) dv = 1;
    if (!clk_mode_q) begin
      top = (dv >> 16) & 16'hFFFF;
      while (top != 0) begin
        top >>= 1;
        ex++;
      end
    end
    spd = (dv >> ex) - 1;
    if (!clk_mode_q) begin
      me = min_exponent(duty_prec_q);
      if (ex < me) begin
        q = rdiv(spd + 1, 64'd1 << (me - ex));
        spd = (q == 0) ? 0 : q - 1;
        ex = me;
      end
      hc = rdiv((64'd1 << ex) * dty, per) & 16'hFFFF;
      if (hc == 0 && dty > 0) hc = 1;
      else if ((64'd1 << ex) <= hc && dty < per) hc--;
    end
    if (spd > 16'hFFFF) spd = 16'hFFFF;
    fq = rdiv(clk_hz_q, 2 * (spd + 1));
    if (!clk_mode_q) fq >>= ex;
    if (fq == 0) fq = 1;
    rch = rdiv(64'd1000000000, fq);
    df = (rch > per) ? rch - per : per - rch;
    er = rdiv(100 * df, per);
    if (er > 16'hFFFF) er = 16'hFFFF;
    s.status   = (er > per_prec_q) ? pds_pkg::ST_PREC : pds_pkg::ST_OK;
    s.speed    = spd[15:0];
    s.expo     = ex[4:0];
    s.high_cnt = hc[15:0];
    s.err_pct  = er[15:0];
    return s;
  endfunction

  // mostly short gaps, some long, none in no-idle stretches
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic cfg_write(logic [1:0] idx, logic [29:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      pds_pkg::CFG_CLOCK_HZ:    clk_hz_q    = val;
      pds_pkg::CFG_SQ_MODE:     clk_mode_q  = val[0];
      pds_pkg::CFG_DUTY_PREC:   duty_prec_q = val[6:0];
      pds_pkg::CFG_PERIOD_PREC: per_prec_q  = val[6:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one request; expectation queued when it is taken
  task automatic send_req(logic [31:0] per, logic [31:0] dty, bit typed, solve_t want);
    int g;
    in_tvalid <= 1'b1;
    in_tdata  <= {dty, per};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    solutions_due.push_back(typed ? want : solve_pwm(per, dty));
    req_cnt++;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (solutions_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(1, 2000);
    if (r < 65) return $urandom_range(1, 2000000);
    if (r < 92) return $urandom_range(1, 32'h7FFFFFFF);
    return $urandom();
  endfunction

  task automatic random_phase(int n);
    logic [31:0] p, d;
    int r;
    for (int i = 0; i < n; i++) begin
      p = rand_period();
      r = $urandom_range(0, 99);
      if (r < 70 && !p[31] && p != 0) d = $urandom_range(0, p);
      else if (r < 80) d = p + $urandom_range(0, 1000);
      else d = $urandom();
      send_req(p, d, 1'b0, '0);
    end
    drain();
  endtask

  // result checker
  always @(posedge clk) begin
    solve_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status   = out_tdata[1:0];
      got.speed    = out_tdata[17:2];
      got.expo     = out_tdata[22:18];
      got.high_cnt = out_tdata[38:23];
      got.err_pct  = out_tdata[54:39];
      res_cnt++;
      if (solutions_due.size() == 0) begin
        $error("result with no request pending");
        fail_cnt++;
      end else begin
        want = solutions_due.pop_front();
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status);
          fail_cnt++;
        end
        if (got.speed !== want.speed) begin
          $error("speed_value exp %0d got %0d", want.speed, got.speed);
          fail_cnt++;
        end
        if (got.expo !== want.expo) begin
          $error("ratio_exponent exp %0d got %0d", want.expo, got.expo);
          fail_cnt++;
        end
        if (got.high_cnt !== want.high_cnt) begin
          $error("high_count exp %0d got %0d", want.high_cnt, got.high_cnt);
          fail_cnt++;
        end
        if (got.err_pct !== want.err_pct) begin
          $error("period_error_pct exp %0d got %0d", want.err_pct, got.err_pct);
          fail_cnt++;
        end
      end
    end
  end

  // receiver stalls in runs of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= gap_len();
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 6000) begin
      $display("timeout waiting for handshake");
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    fail_cnt = 0;
    req_cnt = 0;
    res_cnt = 0;
    idle_cycles = 0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = pds_pkg::CFG_CLOCK_HZ;
    cfg_wdata = '0;
    clk_hz_q = pds_pkg::CLOCK_HZ_RST;
    clk_mode_q = 1'b0;
    duty_prec_q = pds_pkg::PREC_RST;
    per_prec_q = pds_pkg::PREC_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: invalid arguments typed, the rest predicted
    rows = '{
      '{32'd0, 32'd0, 1, INVALID},
      '{32'h80000000, 32'd5, 1, INVALID},
      '{32'hFFFFFFFF, 32'd0, 1, INVALID},
      '{32'd1000, 32'hFFFFFFFF, 1, INVALID},
      '{32'd1000, 32'h80000000, 1, INVALID},
      '{32'd1, 32'd0, 0, '0},
      '{32'd1, 32'd1, 0, '0},
      '{32'd1, 32'd2, 0, '0},
      '{32'd10, 32'd5, 0, '0},
      '{32'd10, 32'd10, 0, '0},
      '{32'd10, 32'd9, 0, '0},
      '{32'd20000, 32'd1, 0, '0},
      '{32'd20000, 32'd19999, 0, '0},
      '{32'd1000000, 32'd500000, 0, '0},
      '{32'h7FFFFFFF, 32'd0, 0, '0},
      '{32'h7FFFFFFF, 32'h7FFFFFFF, 0, '0},
      '{32'h7FFFFFFF, 32'd1, 0, '0},
      '{32'd3, 32'h7FFFFFFF, 0, '0},
      '{32'd1310700, 32'd655350, 0, '0},
      '{32'd20, 32'd0, 0, '0}
    };
    foreach (rows[i]) send_req(rows[i].period, rows[i].duty, rows[i].typed, rows[i].want);
    drain();

    // register sweeps, extremes included
    cfg_write(pds_pkg::CFG_PERIOD_PREC, 30'd0);
    random_phase(150);
    cfg_write(pds_pkg::CFG_CLOCK_HZ, 30'd1);
    cfg_write(pds_pkg::CFG_DUTY_PREC, 30'd0);
    random_phase(150);
    cfg_write(pds_pkg::CFG_CLOCK_HZ, 30'd1000000000);
    cfg_write(pds_pkg::CFG_PERIOD_PREC, 30'd10);
    no_idle = 1'b1;
    random_phase(200);
    no_idle = 1'b0;
    cfg_write(pds_pkg::CFG_SQ_MODE, 30'd1);
    random_phase(200);
    cfg_write(pds_pkg::CFG_CLOCK_HZ, 30'h3FFFFFFF);
    cfg_write(pds_pkg::CFG_PERIOD_PREC, 30'd127);
    random_phase(150);
    cfg_write(pds_pkg::CFG_SQ_MODE, 30'd0);
    cfg_write(pds_pkg::CFG_DUTY_PREC, 30'd127);
    random_phase(150);
    for (int k = 0; k < 6; k++) begin
      cfg_write(pds_pkg::CFG_CLOCK_HZ, $urandom_range(1, 1000000000));
      cfg_write(pds_pkg::CFG_SQ_MODE, $urandom_range(0, 1));
      cfg_write(pds_pkg::CFG_DUTY_PREC, $urandom_range(0, 100));
      cfg_write(pds_pkg::CFG_PERIOD_PREC, $urandom_range(0, 100));
      no_idle = (k == 2);
      random_phase(120);
    end
    no_idle = 1'b0;

    repeat (250) @(posedge clk);
    if (solutions_due.size() != 0) begin
      $error("%0d results never arrived", solutions_due.size());
      fail_cnt++;
    end
    $display("%0d requests sent, %0d results checked across %0d register settings",
             req_cnt, res_cnt, 13);
    if (fail_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ===== pwm_period_duty_solver_top.f =====
+incdir+design
design/pds_pkg.sv
design/pds_pipe.sv
design/pwm_period_duty_solver_top.sv
design/pds_chk.sv
bench/tb_pwm_period_duty_solver_top.sv
